// ----- src/rvsh_pkg.sv -----
// shared types, widths and constants of the raised-cosine velocity shaper
package rvsh_pkg;

   // beat and register port widths
   localparam int IN_W       = 16;
   localparam int BEAT_W     = 3 * IN_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MAG_W      = 15;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_LIN_IN_MAX  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIN_IN_MIN  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIN_OUT_MAX = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIN_OUT_MIN = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_YAW_IN_MAX  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_YAW_IN_MIN  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_YAW_OUT_MAX = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_YAW_OUT_MIN = 3'd7;

   // register reset values
   localparam logic [14:0] RST_LIN_IN_MAX  = 15'd12288;
   localparam logic [14:0] RST_LIN_IN_MIN  = 15'd1229;
   localparam logic [14:0] RST_LIN_OUT_MAX = 15'd15360;
   localparam logic [14:0] RST_LIN_OUT_MIN = 15'd7680;
   localparam logic [15:0] RST_YAW_IN_MAX  = 16'd9216;
   localparam logic [15:0] RST_YAW_IN_MIN  = 16'd192;
   localparam logic [14:0] RST_YAW_OUT_MAX = 15'd5120;
   localparam logic [14:0] RST_YAW_OUT_MIN = 15'd768;

   // shaper input width (magnitude in q4.22, angle in q.16)
   localparam int V_W      = 26;
   localparam int BOUND_SH = 10;

   // square root cells
   localparam int ROOT_W     = 26;
   localparam int RAD_W      = 2 * ROOT_W;
   localparam int REM_W      = ROOT_W + 2;
   localparam int M2_W       = 32;
   localparam int RAD_PAD    = RAD_W - M2_W;

   // divider cells
   localparam int T_W      = 17;
   localparam int Q_W      = 15;
   localparam int DIV_W    = V_W + T_W - 1;
   localparam int SCALE_SH = 11;

   // curve arithmetic
   localparam int POLY_STEPS = 4;
   localparam logic [31:0] PI_Q30      = 32'd3373259426;
   localparam logic [21:0] RAD2DEG_Q16 = 22'd3754936;
   localparam logic [V_W-1:0] DEAD_Q16 = 26'd6554;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [T_W-1:0] T_HALF   = 17'd32768;
   localparam logic [T_W-1:0] T_FULL   = 17'd65536;
   localparam logic [45:0] HALF_Q30    = 46'h0000_2000_0000;

   // exact reciprocals for 32-bit numerators: ceil(2^(32+l)/d), l = ceil(log2 d)
   localparam logic [32:0] POLY_MAGIC [POLY_STEPS] = '{
      33'(((64'd1 << 39) + 64'd89) / 64'd90),
      33'(((64'd1 << 38) + 64'd55) / 64'd56),
      33'(((64'd1 << 37) + 64'd29) / 64'd30),
      33'(((64'd1 << 36) + 64'd11) / 64'd12)
   };
   localparam int POLY_SHIFT [POLY_STEPS] = '{39, 38, 37, 36};

   // shaper result class
   localparam int CLS_W = 2;
   localparam logic [CLS_W-1:0] CLS_CURVE = 2'd0;
   localparam logic [CLS_W-1:0] CLS_MAX   = 2'd1;
   localparam logic [CLS_W-1:0] CLS_MIN   = 2'd2;

   // pipeline depths
   localparam int SHAPE_LAT = 1 + T_W + 2 + 2 * POLY_STEPS + 2;
   localparam int LAT       = 3 + ROOT_W + SHAPE_LAT + 1 + Q_W + 1;
   localparam int SB_N      = LAT - 3;
   localparam int SB_ANG    = ROOT_W;
   localparam int SB_S      = ROOT_W + 1;
   localparam int SB_Y      = ROOT_W + SHAPE_LAT + 1;

   // per-beat side information riding beside the arithmetic
   typedef struct packed {
      logic [IN_W-1:0]   ax;
      logic [IN_W-1:0]   ay;
      logic              neg_x;
      logic              neg_y;
      logic              zero;
      logic              neg_w;
      logic              dead;
      logic [V_W-1:0]    ang;
      logic [ROOT_W-1:0] s;
      logic [MAG_W-1:0]  ymag;
   } sb_type;

endpackage

// ----- src/raised_cosine_velocity_shaper.sv -----
// top level: planar velocity and yaw rate to shaped drive command
// throughput: one beat per cycle; the whole pipeline holds while a rsp beat waits
// depth is set by the 26 square root cells, 17 fraction divider cells,
// the cosine multiplier stages and 15 component divider cells
// reset clears the valid line and loads the register defaults
module raised_cosine_velocity_shaper
   import rvsh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BEAT_W-1:0]     req_tdata,   // vel_x, vel_y, yaw_rate
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [BEAT_W-1:0]     rsp_tdata,   // drive_x, drive_y, drive_yaw
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [14:0] lin_in_max_ff, lin_in_min_ff, lin_out_max_ff, lin_out_min_ff;
   logic [15:0] yaw_in_max_ff, yaw_in_min_ff;
   logic [14:0] yaw_out_max_ff, yaw_out_min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_in_max_ff  <= RST_LIN_IN_MAX;
         lin_in_min_ff  <= RST_LIN_IN_MIN;
         lin_out_max_ff <= RST_LIN_OUT_MAX;
         lin_out_min_ff <= RST_LIN_OUT_MIN;
         yaw_in_max_ff  <= RST_YAW_IN_MAX;
         yaw_in_min_ff  <= RST_YAW_IN_MIN;
         yaw_out_max_ff <= RST_YAW_OUT_MAX;
         yaw_out_min_ff <= RST_YAW_OUT_MIN;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_LIN_IN_MAX:  lin_in_max_ff  <= csr_wdata[14:0];
            CSR_LIN_IN_MIN:  lin_in_min_ff  <= csr_wdata[14:0];
            CSR_LIN_OUT_MAX: lin_out_max_ff <= csr_wdata[14:0];
            CSR_LIN_OUT_MIN: lin_out_min_ff <= csr_wdata[14:0];
            CSR_YAW_IN_MAX:  yaw_in_max_ff  <= csr_wdata;
            CSR_YAW_IN_MIN:  yaw_in_min_ff  <= csr_wdata;
            CSR_YAW_OUT_MAX: yaw_out_max_ff <= csr_wdata[14:0];
            CSR_YAW_OUT_MIN: yaw_out_min_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   // one valid bit per stage; everything moves together
   logic [LAT-1:0] vld_ff;
   logic           adv;

   assign adv        = ~vld_ff[LAT-1] | rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // stage 1: magnitudes and signs
   logic signed [IN_W-1:0] vx, vy, vw;
   logic [IN_W-1:0] ax1_ff, ay1_ff, aw1_ff;
   logic            nx1_ff, ny1_ff, nw1_ff;

   assign vx = req_tdata[IN_W-1:0];
   assign vy = req_tdata[2*IN_W-1:IN_W];
   assign vw = req_tdata[3*IN_W-1:2*IN_W];

   // stage 2: squares and the degree conversion product
   logic [31:0]     sqx2_ff, sqy2_ff;
   logic [37:0]     wp2_ff;
   logic [IN_W-1:0] ax2_ff, ay2_ff;
   logic            nx2_ff, ny2_ff, nw2_ff;

   // stage 3: squared length and yaw angle in q.16 degrees
   logic [M2_W-1:0] m2_ff;
   logic [V_W-1:0]  ang_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         ax1_ff  <= vx[IN_W-1] ? IN_W'(-vx) : IN_W'(vx);
         ay1_ff  <= vy[IN_W-1] ? IN_W'(-vy) : IN_W'(vy);
         aw1_ff  <= vw[IN_W-1] ? IN_W'(-vw) : IN_W'(vw);
         nx1_ff  <= vx[IN_W-1];
         ny1_ff  <= vy[IN_W-1];
         nw1_ff  <= vw[IN_W-1];
         sqx2_ff <= {16'd0, ax1_ff} * {16'd0, ax1_ff};
         sqy2_ff <= {16'd0, ay1_ff} * {16'd0, ay1_ff};
         wp2_ff  <= {22'd0, aw1_ff} * {16'd0, RAD2DEG_Q16};
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
         nx2_ff  <= nx1_ff;
         ny2_ff  <= ny1_ff;
         nw2_ff  <= nw1_ff;
         m2_ff   <= sqx2_ff + sqy2_ff;
      end
   end

   assign ang_in = wp2_ff[37:12];

   // side information line, index i holds stage 3 + i
   sb_type sd_ff [0:SB_N-1];
   sb_type sd_in [0:SB_N-1];
   sb_type sd_head;
   logic [ROOT_W-1:0] root_s;
   logic [MAG_W-1:0]  lin_mag, yaw_mag;

   always_comb begin
      sd_head       = '0;
      sd_head.ax    = ax2_ff;
      sd_head.ay    = ay2_ff;
      sd_head.neg_x = nx2_ff;
      sd_head.neg_y = ny2_ff;
      sd_head.neg_w = nw2_ff;
      sd_head.zero  = (ax2_ff == '0) && (ay2_ff == '0);
      sd_head.dead  = (ang_in < DEAD_Q16);
      sd_head.ang   = ang_in;
      sd_in[0]      = sd_head;
      for (int i = 1; i < SB_N; i++) begin
         sd_in[i] = sd_ff[i-1];
      end
      // root joins once the square root cells finish, yaw result after shaping
      sd_in[SB_S].s    = root_s;
      sd_in[SB_Y].ymag = yaw_mag;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < SB_N; i++) begin
            sd_ff[i] <= sd_in[i];
         end
      end
   end

   // square root of m2 << 20: one cell per root bit
   logic [RAD_W-1:0]  rad_w  [0:ROOT_W-1];
   logic [ROOT_W-1:0] root_w [0:ROOT_W];
   logic [REM_W-1:0]  rem_w  [0:ROOT_W-1];

   assign rad_w[0]  = {m2_ff, {RAD_PAD{1'b0}}};
   assign root_w[0] = '0;
   assign rem_w[0]  = '0;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      if (i < ROOT_W - 1) begin : g_mid
         rvsh_sqrt_cell u_cell (
            .clock    (clock),
            .en       (adv),
            .rad_in   (rad_w[i]),
            .root_in  (root_w[i]),
            .rem_in   (rem_w[i]),
            .rad_out  (rad_w[i+1]),
            .root_out (root_w[i+1]),
            .rem_out  (rem_w[i+1])
         );
      end else begin : g_last
         rvsh_sqrt_cell u_cell (
            .clock    (clock),
            .en       (adv),
            .rad_in   (rad_w[i]),
            .root_in  (root_w[i]),
            .rem_in   (rem_w[i]),
            .rad_out  (),
            .root_out (root_w[i+1]),
            .rem_out  ()
         );
      end
   end

   assign root_s = root_w[ROOT_W];

   // linear and yaw shapers run side by side
   rvsh_shape u_lin_shape (
      .clock (clock),
      .en    (adv),
      .v     (root_s),
      .lo    (V_W'({lin_in_min_ff, {BOUND_SH{1'b0}}})),
      .hi    (V_W'({lin_in_max_ff, {BOUND_SH{1'b0}}})),
      .omin  (lin_out_min_ff),
      .omax  (lin_out_max_ff),
      .mag   (lin_mag)
   );

   rvsh_shape u_yaw_shape (
      .clock (clock),
      .en    (adv),
      .v     (sd_ff[SB_ANG].ang),
      .lo    (V_W'({yaw_in_min_ff, {BOUND_SH{1'b0}}})),
      .hi    (V_W'({yaw_in_max_ff, {BOUND_SH{1'b0}}})),
      .omin  (yaw_out_min_ff),
      .omax  (yaw_out_max_ff),
      .mag   (yaw_mag)
   );

   // component scaling: (2 * mag * |c| * 1024 + s) / (2 * s)
   sb_type           sb_lin;
   logic [30:0]      px, py;
   logic [DIV_W-1:0] nx_ff, ny_ff, dd_ff;

   assign sb_lin = sd_ff[SB_Y-1];
   assign px     = {16'd0, lin_mag} * {15'd0, sb_lin.ax};
   assign py     = {16'd0, lin_mag} * {15'd0, sb_lin.ay};

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff <= DIV_W'({px, {SCALE_SH{1'b0}}}) + DIV_W'(sb_lin.s);
         ny_ff <= DIV_W'({py, {SCALE_SH{1'b0}}}) + DIV_W'(sb_lin.s);
         dd_ff <= DIV_W'({sb_lin.s, {Q_W{1'b0}}});
      end
   end

   logic [DIV_W-1:0] xr_w [0:Q_W-1];
   logic [DIV_W-1:0] xd_w [0:Q_W-1];
   logic [Q_W-1:0]   xq_w [0:Q_W];
   logic [DIV_W-1:0] yr_w [0:Q_W-1];
   logic [DIV_W-1:0] yd_w [0:Q_W-1];
   logic [Q_W-1:0]   yq_w [0:Q_W];

   assign xr_w[0] = nx_ff;
   assign xd_w[0] = dd_ff;
   assign xq_w[0] = '0;
   assign yr_w[0] = ny_ff;
   assign yd_w[0] = dd_ff;
   assign yq_w[0] = '0;

   for (genvar i = 0; i < Q_W; i++) begin : g_sdiv
      if (i < Q_W - 1) begin : g_mid
         rvsh_div_cell #(.W(DIV_W), .QW(Q_W)) u_xdiv (
            .clock (clock), .en (adv),
            .r_in  (xr_w[i]), .d_in (xd_w[i]), .q_in (xq_w[i]),
            .r_out (xr_w[i+1]), .d_out (xd_w[i+1]), .q_out (xq_w[i+1])
         );
         rvsh_div_cell #(.W(DIV_W), .QW(Q_W)) u_ydiv (
            .clock (clock), .en (adv),
            .r_in  (yr_w[i]), .d_in (yd_w[i]), .q_in (yq_w[i]),
            .r_out (yr_w[i+1]), .d_out (yd_w[i+1]), .q_out (yq_w[i+1])
         );
      end else begin : g_last
         rvsh_div_cell #(.W(DIV_W), .QW(Q_W)) u_xdiv (
            .clock (clock), .en (adv),
            .r_in  (xr_w[i]), .d_in (xd_w[i]), .q_in (xq_w[i]),
            .r_out (), .d_out (), .q_out (xq_w[i+1])
         );
         rvsh_div_cell #(.W(DIV_W), .QW(Q_W)) u_ydiv (
            .clock (clock), .en (adv),
            .r_in  (yr_w[i]), .d_in (yd_w[i]), .q_in (yq_w[i]),
            .r_out (), .d_out (), .q_out (yq_w[i+1])
         );
      end
   end

   // output register: signs back on, zero vector and dead zone forced to zero
   sb_type          sb_out;
   logic [IN_W-1:0] qx, qy, qw;
   logic [IN_W-1:0] drive_x_ff, drive_y_ff, drive_yaw_ff;
   logic [IN_W-1:0] drive_x_in, drive_y_in, drive_yaw_in;

   assign sb_out = sd_ff[SB_N-1];
   assign qx     = {1'b0, xq_w[Q_W]};
   assign qy     = {1'b0, yq_w[Q_W]};
   assign qw     = {1'b0, sb_out.ymag};

   always_comb begin
      drive_x_in   = sb_out.zero ? '0 : (sb_out.neg_x ? IN_W'(-qx) : qx);
      drive_y_in   = sb_out.zero ? '0 : (sb_out.neg_y ? IN_W'(-qy) : qy);
      drive_yaw_in = sb_out.dead ? '0 : (sb_out.neg_w ? IN_W'(-qw) : qw);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         drive_x_ff   <= drive_x_in;
         drive_y_ff   <= drive_y_in;
         drive_yaw_ff <= drive_yaw_in;
      end
   end

   assign rsp_tdata = {drive_yaw_ff, drive_y_ff, drive_x_ff};

   // checks
   logic [IN_W-1:0]  abs_x, abs_yaw;
   logic [MAG_W-1:0] lin_hi, yaw_lo, yaw_hi;

   assign abs_x   = drive_x_ff[IN_W-1] ? IN_W'(-drive_x_ff) : drive_x_ff;
   assign abs_yaw = drive_yaw_ff[IN_W-1] ? IN_W'(-drive_yaw_ff) : drive_yaw_ff;
   assign lin_hi  = (lin_out_max_ff >= lin_out_min_ff) ? lin_out_max_ff : lin_out_min_ff;
   assign yaw_hi  = (yaw_out_max_ff >= yaw_out_min_ff) ? yaw_out_max_ff : yaw_out_min_ff;
   assign yaw_lo  = (yaw_out_max_ff >= yaw_out_min_ff) ? yaw_out_min_ff : yaw_out_max_ff;

   // a held rsp beat freezes the whole valid line
   assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while rsp beat stalled");

   // the x component never exceeds the top of the linear output range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> abs_x <= {1'b0, lin_hi})
      else $error("drive_x beyond linear output range");

   // a nonzero yaw drive lies inside the yaw output range
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && drive_yaw_ff != '0 |->
         abs_yaw >= {1'b0, yaw_lo} && abs_yaw <= {1'b0, yaw_hi})
      else $error("drive_yaw outside yaw output range");

endmodule

// ----- src/rvsh_sqrt_cell.sv -----
// one restoring square root cell, one root bit per stage
module rvsh_sqrt_cell
   import rvsh_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  rad_in,
   input  logic [ROOT_W-1:0] root_in,
   input  logic [REM_W-1:0]  rem_in,
   output logic [RAD_W-1:0]  rad_out,
   output logic [ROOT_W-1:0] root_out,
   output logic [REM_W-1:0]  rem_out
);

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W-1:0] root_ff, root_in_nx;
   logic [REM_W-1:0]  rem_ff, rem_in_nx;
   logic [REM_W+1:0]  part, trial, diff;
   logic              ge;

   always_comb begin
      part  = {rem_in, rad_in[RAD_W-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      diff  = part - trial;
      ge    = (part >= trial);
      rem_in_nx  = ge ? diff[REM_W-1:0] : part[REM_W-1:0];
      root_in_nx = {root_in[ROOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in << 2;
         root_ff <= root_in_nx;
         rem_ff  <= rem_in_nx;
      end
   end

   assign rad_out  = rad_ff;
   assign root_out = root_ff;
   assign rem_out  = rem_ff;

endmodule

// ----- src/rvsh_div_cell.sv -----
// one restoring divider cell, one quotient bit per stage
module rvsh_div_cell
   import rvsh_pkg::*;
#(
   parameter int W  = DIV_W,
   parameter int QW = T_W
)
(
   input  logic          clock,
   input  logic          en,
   input  logic [W-1:0]  r_in,
   input  logic [W-1:0]  d_in,
   input  logic [QW-1:0] q_in,
   output logic [W-1:0]  r_out,
   output logic [W-1:0]  d_out,
   output logic [QW-1:0] q_out
);

   logic [W-1:0]  r_ff, d_ff;
   logic [QW-1:0] q_ff;
   logic [W:0]    diff;
   logic          ge;

   assign diff = {1'b0, r_in} - {1'b0, d_in};
   assign ge   = ~diff[W];

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= ge ? diff[W-1:0] : r_in;
         d_ff <= d_in >> 1;
         q_ff <= {q_in[QW-2:0], ge};
      end
   end

   assign r_out = r_ff;
   assign d_out = d_ff;
   assign q_out = q_ff;

endmodule

// ----- src/rvsh_poly_cell.sv -----
// one horner step of the cosine series: divide by a constant, subtract from one, then scale by x2
module rvsh_poly_cell
   import rvsh_pkg::*;
#(
   parameter logic [32:0] MAGIC = POLY_MAGIC[0],
   parameter int          SHIFT = POLY_SHIFT[0]
)
(
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] p_in,
   input  logic [31:0] x2_in,
   output logic [31:0] p_out,
   output logic [31:0] x2_out
);

   logic [64:0] prod_a;
   logic [30:0] q_ff, q_in;
   logic [31:0] x2a_ff, x2b_ff, p_ff;
   logic [30:0] a_term;
   logic [62:0] prod_b;

   assign prod_a = {33'd0, p_in} * {32'd0, MAGIC};
   assign q_in   = 31'(prod_a >> SHIFT);
   assign a_term = ONE_Q30 - q_ff;
   assign prod_b = {31'd0, x2a_ff} * {32'd0, a_term};

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff   <= q_in;
         x2a_ff <= x2_in;
         p_ff   <= prod_b[61:30];
         x2b_ff <= x2a_ff;
      end
   end

   assign p_out  = p_ff;
   assign x2_out = x2b_ff;

endmodule

// ----- src/rvsh_shape.sv -----
// maps a value against [lo, hi] onto [omin, omax] with a raised-cosine curve
module rvsh_shape
   import rvsh_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [V_W-1:0]   v,
   input  logic [V_W-1:0]   lo,
   input  logic [V_W-1:0]   hi,
   input  logic [MAG_W-1:0] omin,
   input  logic [MAG_W-1:0] omax,
   output logic [MAG_W-1:0] mag
);

   localparam int CLS_N = SHAPE_LAT - 1;
   localparam int UP_N  = 2 + 2 * POLY_STEPS;

   logic [CLS_W-1:0] cls_ff [0:CLS_N-1];
   logic [CLS_W-1:0] cls_in;
   logic             up_ff [0:UP_N-1];
   logic [V_W-1:0]   numer_ff, den_ff;

   logic [DIV_W-1:0] dr_w [0:T_W];
   logic [DIV_W-1:0] dd_w [0:T_W];
   logic [T_W-1:0]   dq_w [0:T_W];

   logic [31:0]      p_w  [0:POLY_STEPS];
   logic [31:0]      x2_w [0:POLY_STEPS-1];

   logic [T_W-1:0]   t;
   logic             upper;
   logic [15:0]      h;
   logic [47:0]      hx;
   logic [30:0]      x_ff;
   logic [61:0]      xx;
   logic [31:0]      x2_ff;
   logic [30:0]      g, f;
   logic [MAG_W-1:0] dmag, delta_ff, mag_ff, mag_in;
   logic [45:0]      df;

   // classify and set up the fraction
   always_comb begin
      if (v > hi) begin
         cls_in = CLS_MAX;
      end else if (v < lo) begin
         cls_in = CLS_MIN;
      end else if (hi == lo) begin
         cls_in = CLS_MAX;
      end else begin
         cls_in = CLS_CURVE;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         numer_ff  <= v - lo;
         den_ff    <= hi - lo;
         cls_ff[0] <= cls_in;
         for (int i = 1; i < CLS_N; i++) begin
            cls_ff[i] <= cls_ff[i-1];
         end
      end
   end

   // t = ((v - lo) << 16) / (hi - lo)
   assign dr_w[0] = {numer_ff, {(T_W-1){1'b0}}};
   assign dd_w[0] = {den_ff, {(T_W-1){1'b0}}};
   assign dq_w[0] = '0;

   for (genvar i = 0; i < T_W; i++) begin : g_div
      rvsh_div_cell #(.W(DIV_W), .QW(T_W)) u_div (
         .clock (clock),
         .en    (en),
         .r_in  (dr_w[i]),
         .d_in  (dd_w[i]),
         .q_in  (dq_w[i]),
         .r_out (dr_w[i+1]),
         .d_out (dd_w[i+1]),
         .q_out (dq_w[i+1])
      );
   end

   // fold to the lower half, x = pi * h
   assign t     = dq_w[T_W];
   assign upper = (t > T_HALF);
   assign h     = upper ? 16'(T_FULL - t) : t[15:0];
   assign hx    = {16'd0, h} * {16'd0, PI_Q30};
   assign xx    = {31'd0, x_ff} * {31'd0, x_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff     <= hx[46:16];
         up_ff[0] <= upper;
         x2_ff    <= xx[61:30];
         for (int i = 1; i < UP_N; i++) begin
            up_ff[i] <= up_ff[i-1];
         end
      end
   end

   // series x2 (1 - x2/12 (1 - x2/30 (1 - x2/56 (1 - x2/90))))
   assign p_w[0]  = x2_ff;
   assign x2_w[0] = x2_ff;

   for (genvar i = 0; i < POLY_STEPS; i++) begin : g_poly
      if (i < POLY_STEPS - 1) begin : g_mid
         rvsh_poly_cell #(.MAGIC(POLY_MAGIC[i]), .SHIFT(POLY_SHIFT[i])) u_poly (
            .clock  (clock),
            .en     (en),
            .p_in   (p_w[i]),
            .x2_in  (x2_w[i]),
            .p_out  (p_w[i+1]),
            .x2_out (x2_w[i+1])
         );
      end else begin : g_last
         rvsh_poly_cell #(.MAGIC(POLY_MAGIC[i]), .SHIFT(POLY_SHIFT[i])) u_poly (
            .clock  (clock),
            .en     (en),
            .p_in   (p_w[i]),
            .x2_in  (x2_w[i]),
            .p_out  (p_w[i+1]),
            .x2_out ()
         );
      end
   end

   // scale the curve onto the output span, rounded
   assign g    = p_w[POLY_STEPS][31:1];
   assign f    = up_ff[UP_N-1] ? (ONE_Q30 - g) : g;
   assign dmag = (omax >= omin) ? (omax - omin) : (omin - omax);
   assign df   = ({31'd0, dmag} * {15'd0, f}) + HALF_Q30;

   always_comb begin
      case (cls_ff[CLS_N-1])
         CLS_MAX:   mag_in = omax;
         CLS_MIN:   mag_in = omin;
         CLS_CURVE: mag_in = (omax >= omin) ? (omin + delta_ff) : (omin - delta_ff);
         default:   mag_in = omin;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         delta_ff <= df[44:30];
         mag_ff   <= mag_in;
      end
   end

   assign mag = mag_ff;

endmodule
